@@ src/stbs_pkg.sv @@
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_BITS  = 32;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int LEN_BITS    = 11;
	localparam int PROBE_BITS  = 4;

	// Transaction kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [LEN_BITS-1:0]          len_t;
	// Interval bound, holds 0 .. TABLE_DEPTH
	typedef logic [IDX_BITS:0]            bound_t;
	typedef logic [PROBE_BITS-1:0]        probe_t;

	typedef struct packed {
		logic   done;
		logic   found;
		idx_t   match_index;
		probe_t probe_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_PROBE   = 3'b010,
		ST_COMPARE = 3'b100
	} state_t;

endpackage

@@ src/stbs_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/stbs_ctrl.sv @@
// Search sequencer: interval bounds, midpoint probe and the shared compare.
module stbs_ctrl import stbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_start,
	input  value_t  query_target,
	input  len_t    length,
	output idx_t    rd_addr,
	input  value_t  rd_data,
	output logic    busy,
	output result_t result
);

	state_t  state_q;
	bound_t  low_q;
	bound_t  hi_q;      // exclusive upper bound
	idx_t    mid_q;
	probe_t  probes_q;
	value_t  target_q;
	logic    done_q;
	logic    found_q;
	idx_t    match_q;
	probe_t  count_q;

	logic [IDX_BITS+1:0] mid_sum;
	idx_t                mid;
	bound_t              len_sat;
	logic                empty;
	logic                hit;
	logic                less;

	// Saturate the length to the table depth
	assign len_sat = (length > LEN_BITS'(TABLE_DEPTH)) ? bound_t'(TABLE_DEPTH)
	                                                    : bound_t'(length);

	// Midpoint of [low, hi): floor((low + hi - 1) / 2)
	assign mid_sum = {1'b0, low_q} + {1'b0, hi_q} - (IDX_BITS+2)'(1);
	assign mid     = mid_sum[IDX_BITS:1];
	assign empty   = (low_q >= hi_q);

	// Shared compare unit
	assign hit  = (rd_data == target_q);
	assign less = (rd_data < target_q);

	assign rd_addr = mid;
	assign busy    = (state_q != ST_IDLE);
	assign result  = '{done: done_q, found: found_q, match_index: match_q,
	                   probe_count: count_q};

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (empty) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_COMPARE;
					end
				end
				ST_COMPARE: begin
					if (hit) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (query_start) begin
					target_q <= query_target;
					low_q    <= '0;
					hi_q     <= len_sat;
					probes_q <= '0;
				end
			end
			ST_PROBE: begin
				mid_q <= mid;
				if (empty) begin
					found_q <= 1'b0;
					match_q <= '0;
					count_q <= probes_q;
				end
			end
			ST_COMPARE: begin
				probes_q <= probes_q + probe_t'(1);
				if (hit) begin
					found_q <= 1'b1;
					match_q <= mid_q;
					count_q <= probes_q + probe_t'(1);
				end else if (less) begin
					low_q <= bound_t'(mid_q) + bound_t'(1);
				end else begin
					hi_q <= bound_t'(mid_q);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobed while search still running");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (match_q == '0))
		else $error("miss reported a nonzero index");

	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> (low_q < hi_q))
		else $error("compare on an empty interval");

	a_probe_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (count_q <= probe_t'(IDX_BITS + 1)))
		else $error("probe count beyond table height");
`endif

endmodule

@@ src/sorted_table_binary_search.sv @@
// A load transaction (kind 0) writes one table entry in the cycle it is taken and
// leaves busy low; it returns no result. A query transaction (kind 1) raises busy
// and runs a binary search over the first table_length entries (saturated to the
// table depth): each probe reads the midpoint from the single table read port in
// the PROBE state and compares it in the COMPARE state, with at most 11 probes for
// 1024 entries; a miss ends with one more PROBE on the empty interval. The result
// appears with done high for exactly one cycle as busy falls; it cannot be held
// off, so the receiver must take it then. The user must write table_length through
// cfg_we/cfg_data only while no query runs; the block does not enforce this.
module sorted_table_binary_search import stbs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  logic   kind,
	input  idx_t   entry_index,
	input  value_t entry_value,
	input  value_t target,
	input  logic   cfg_we,
	input  len_t   cfg_data,
	output logic   done,
	output logic   found,
	output idx_t   match_index,
	output probe_t probe_count
);

	len_t    length_q;
	logic    accept;
	logic    load_we;
	logic    query_start;
	idx_t    rd_addr;
	value_t  rd_data;
	result_t result;

	assign accept      = start && !busy;
	assign load_we     = accept && (kind == KIND_LOAD);
	assign query_start = accept && (kind == KIND_QUERY);

	// Table length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cfg_we) begin
			length_q <= cfg_data;
		end
	end

	// Table storage
	stbs_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (entry_index),
		.wdata (entry_value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Search sequencer
	stbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_start  (query_start),
		.query_target (target),
		.length       (length_q),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.busy         (busy),
		.result       (result)
	);

	assign done        = result.done;
	assign found       = result.found;
	assign match_index = result.match_index;
	assign probe_count = result.probe_count;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the sorted table binary search block.
module testbench;
	import stbs_pkg::*;

	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam value_t VALUE_MAX = ~VALUE_MIN;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	logic   kind;
	idx_t   entry_index;
	value_t entry_value;
	value_t target;
	logic   cfg_we;
	len_t   cfg_data;
	logic   done;
	logic   found;
	idx_t   match_index;
	probe_t probe_count;

	// One search answer as the block should report it
	typedef struct {
		logic   found;
		idx_t   index;
		probe_t probes;
	} search_answer_t;

	// Behavioral copy of the table and the length register
	value_t         model_table [TABLE_DEPTH];
	len_t           model_length;
	search_answer_t pending_answers [$];
	int             mismatches;
	int             items_sent;
	bit             burst;

	sorted_table_binary_search DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.target     (target),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.done       (done),
		.found      (found),
		.match_index(match_index),
		.probe_count(probe_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Binary search over the live prefix, same probe and narrow rule as the block
	function automatic search_answer_t predict_search(value_t tgt);
		search_answer_t a;
		int lo, hi, mid, len;
		a.found  = 1'b0;
		a.index  = '0;
		a.probes = '0;
		len = (model_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_length);
		lo = 0;
		hi = len - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			a.probes = a.probes + 1'b1;
			if (model_table[mid] == tgt) begin
				a.found = 1'b1;
				a.index = idx_t'(mid);
				lo = hi + 1;
			end else if (model_table[mid] < tgt) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return a;
	endfunction

	// Random word, extremes now and then
	function automatic value_t rand_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return VALUE_MIN;
		if (r == 1) return VALUE_MAX;
		return value_t'($urandom);
	endfunction

	// Mostly hits and near misses on the live prefix, some random targets
	function automatic value_t rand_target();
		int len, r;
		len = (model_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_length);
		r = $urandom_range(0, 99);
		if (len > 0 && r < 50) return model_table[$urandom_range(0, len - 1)];
		if (len > 0 && r < 75) begin
			if (r[0]) return model_table[$urandom_range(0, len - 1)] + 1;
			return model_table[$urandom_range(0, len - 1)] - 1;
		end
		if (r < 82) return r[0] ? VALUE_MIN : VALUE_MAX;
		return value_t'($urandom);
	endfunction

	// Drive one transaction, wait for acceptance, then update the model
	task automatic send_item(logic k, idx_t idx, value_t val, value_t tgt);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 17);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start       = 1'b1;
		kind        = k;
		entry_index = idx;
		entry_value = val;
		target      = tgt;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (k == KIND_LOAD)
			model_table[idx] = val;
		else
			pending_answers.push_back(predict_search(tgt));
		items_sent++;
	endtask

	task automatic load_entry(idx_t idx, value_t val);
		send_item(KIND_LOAD, idx, val, value_t'($urandom));
	endtask

	task automatic query(value_t tgt);
		send_item(KIND_QUERY, idx_t'($urandom), value_t'($urandom), tgt);
	endtask

	// Stop sending, let all answers come back, then allow the pipeline to settle
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_length(len_t v);
		wait_idle();
		cfg_we   = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we       = 1'b0;
		model_length = v;
	endtask

	// Ascending prefix 0..count-1, saturating at the top of the range
	task automatic load_sorted(int count, longint first_value, int unsigned step_max);
		longint cur;
		cur = first_value;
		for (int i = 0; i < count; i++) begin
			load_entry(idx_t'(i), value_t'(cur));
			cur = cur + $urandom_range(0, step_max);
			if (cur > longint'(VALUE_MAX)) cur = longint'(VALUE_MAX);
		end
	endtask

	// Length register straight out of reset: empty table
	task automatic test_reset_length();
		query(VALUE_MIN);
		query(VALUE_MAX);
		query(0);
	endtask

	// Eight entries spanning the value range, hits on every slot and misses, then lengths of one and zero
	task automatic test_small_table();
		value_t small_set [8];
		small_set = '{VALUE_MIN, -1000, -1, 0, 1, 65535, VALUE_MAX - 1, VALUE_MAX};
		for (int i = 0; i < 8; i++) load_entry(idx_t'(i), small_set[i]);
		set_length(len_t'(8));
		for (int i = 0; i < 8; i++) query(small_set[i]);
		query(-500);
		query(2);
		query(70000);
		set_length(len_t'(1));
		query(VALUE_MIN);
		query(12345);
		set_length(len_t'(0));
		query(0);
	endtask

	// Whole table, full depth and lengths that saturate
	task automatic test_full_table();
		load_sorted(TABLE_DEPTH, longint'(VALUE_MIN) + $urandom_range(0, 255), 1 << 22);
		set_length(len_t'(1024));
		repeat (40) query(rand_target());
		set_length(len_t'(2047));
		repeat (20) query(rand_target());
		set_length(len_t'(1025));
		repeat (10) query(rand_target());
	endtask

	// Phases: rewrite a prefix (usually sorted), stray loads, new length, queries
	task automatic test_random_traffic();
		int r, len;
		int unsigned step_max;
		longint first_value;
		while (items_sent < 1800) begin
			burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) len = $urandom_range(1, 40);
			else if (r < 86) len = $urandom_range(41, 120);
			else if (r < 90) len = $urandom_range(121, 1023);
			else if (r < 94) len = 0;
			else len = $urandom_range(1024, 2047);
			// Short prefixes are mostly rewritten sorted; the rest keep stale contents
			if (len > 0 && len <= 120 && $urandom_range(0, 6) != 0) begin
				first_value = ($urandom_range(0, 4) == 0) ?
					longint'(VALUE_MIN) : longint'(int'($urandom));
				case ($urandom_range(0, 3))
					0: step_max = 3;
					1: step_max = 1000;
					2: step_max = 1 << 20;
					default: step_max = 1 << 28;
				endcase
				load_sorted(len, first_value, step_max);
			end
			repeat ($urandom_range(0, 2)) load_entry(idx_t'($urandom), rand_value());
			set_length(len_t'(len));
			repeat ($urandom_range(4, 20)) query(rand_target());
		end
		burst = 1'b0;
	endtask

	// Compare each result with the oldest pending answer
	always @(posedge clk) begin
		search_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: found=%0d index=%0d probes=%0d",
						found, match_index, probe_count);
			end else begin
				want = pending_answers.pop_front();
				if (found !== want.found || match_index !== want.index ||
						probe_count !== want.probes) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected found=%0d index=%0d probes=%0d,",
							want.found, want.index, want.probes,
							" got found=%0d index=%0d probes=%0d",
							found, match_index, probe_count);
				end
			end
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_LOAD;
		entry_index  = '0;
		entry_value  = '0;
		target       = '0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		model_length = '0;
		mismatches   = 0;
		items_sent   = 0;
		burst        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_length();
		test_small_table();
		test_full_table();
		test_random_traffic();

		wait_idle();
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10000000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_ctrl.sv
src/sorted_table_binary_search.sv
tb/sv/testbench.sv
